// ----- hdl/programmable_sound_generator_assert.svh -----
// assertion macros for the sound generator, clocked on clk and disabled during reset
`ifndef PROGRAMMABLE_SOUND_GENERATOR_ASSERT_SVH
`define PROGRAMMABLE_SOUND_GENERATOR_ASSERT_SVH

// same-cycle implication
`define PGSND_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PGSND_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pgsnd_pkg.sv -----
// shared constants, types and the volume table of the sound generator
`timescale 1ns / 1ps
`default_nettype none

package pgsnd_pkg;

    localparam int PRESCALE = 16;
    localparam int PERIOD_W = 10;
    // reload value is at most 1023 * PRESCALE
    localparam int RLD_W    = $clog2(1023 * PRESCALE + 1);
    // down counter: signed, holds -255 up to the largest reload
    localparam int CNT_W    = RLD_W + 1;
    // shared adder: wide enough for the counters and the four-way mix sum
    localparam int ADD_W    = (CNT_W + 1 > 19) ? CNT_W + 1 : 19;
    localparam int NOISE_W  = 15;
    localparam logic [NOISE_W-1:0] NOISE_SEED = 15'h4000;

    typedef struct packed {
        logic [RLD_W-1:0] reload;  // reload of the selected channel
        logic             white;   // noise feedback mode
        logic [15:0]      amp;     // unsigned q15 amplitude of the mix channel
    } pgsnd_rd_t;

    // attenuation to q15 amplitude, entry 0 is full scale
    function automatic logic [15:0] amp_q15(input logic [3:0] att);
        logic [15:0] a;
        case (att)
            4'd0:    a = 16'd32768;
            4'd1:    a = 16'd26028;
            4'd2:    a = 16'd20677;
            4'd3:    a = 16'd16423;
            4'd4:    a = 16'd13045;
            4'd5:    a = 16'd10361;
            4'd6:    a = 16'd8231;
            4'd7:    a = 16'd6537;
            4'd8:    a = 16'd5194;
            4'd9:    a = 16'd4125;
            4'd10:   a = 16'd3277;
            4'd11:   a = 16'd2602;
            4'd12:   a = 16'd2068;
            4'd13:   a = 16'd1642;
            4'd14:   a = 16'd1304;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/pgsnd_regs.sv -----
// register byte decoder, period and attenuation registers, reload lookup
`timescale 1ns / 1ps
`default_nettype none

module pgsnd_regs
    import pgsnd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire logic [7:0] wr_data,
    input  wire logic [1:0] ch_sel,
    input  wire logic [1:0] mix_sel,
    output pgsnd_rd_t       rd
);

    logic [3:0] per_lo_reg [4];
    logic [5:0] per_hi_reg [4];
    logic [3:0] att_reg    [4];
    logic [1:0] latched_index_reg;
    logic       latched_vol_reg;

    function automatic logic [RLD_W-1:0] tone_rld(input logic [PERIOD_W-1:0] p);
        logic [PERIOD_W-1:0] pz;
        pz = (p == '0) ? PERIOD_W'(1) : p;
        return RLD_W'(RLD_W'(pz) * RLD_W'(PRESCALE));
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                per_lo_reg[i] <= '0;
                per_hi_reg[i] <= '0;
                att_reg[i]    <= '0;
            end
            latched_index_reg <= '0;
            latched_vol_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            if (wr_data[7])
            begin
                // latch byte: channel, register select, low nibble
                latched_index_reg <= wr_data[6:5];
                latched_vol_reg   <= wr_data[4];
                if (wr_data[4])
                    att_reg[wr_data[6:5]] <= wr_data[3:0];
                else
                    per_lo_reg[wr_data[6:5]] <= wr_data[3:0];
            end
            else if (latched_vol_reg)
                att_reg[latched_index_reg] <= wr_data[3:0];
            else
                per_hi_reg[latched_index_reg] <= wr_data[5:0];
        end
    end

    logic [RLD_W-1:0] noise_rld;

    always_comb
    begin
        case (per_lo_reg[3][1:0])
            2'd0:    noise_rld = RLD_W'(PRESCALE);
            2'd1:    noise_rld = RLD_W'(2 * PRESCALE);
            2'd2:    noise_rld = RLD_W'(4 * PRESCALE);
            default: noise_rld = tone_rld({per_hi_reg[2], per_lo_reg[2]});
        endcase
    end

    assign rd.reload = (ch_sel == 2'd3) ? noise_rld
                                        : tone_rld({per_hi_reg[ch_sel], per_lo_reg[ch_sel]});
    assign rd.white  = per_lo_reg[3][2];
    assign rd.amp    = amp_q15(att_reg[mix_sel]);

endmodule

`default_nettype wire

// ----- hdl/programmable_sound_generator.sv -----
// top level of the sound generator: sequencer, shared adder, counters and mixer
//
//  channel | signals                          | direction | item
//  --------+----------------------------------+-----------+-----------------------------
//  in      | in_valid in_stall kind data cycles | to block  | register byte or time tick
//  out     | out_valid out_stall mixed_sample channel_levels | from block | mixed sample
//
//  one adder does every add: counter decrement, each reload, then four mix steps
//  write item: accept, then the four mix steps, then the result register (via hold if stalled)
//  tick item: accept, the decrement and reload steps of each channel, then the four mix steps
//  (each channel takes one decrement step and one step per reload, up to 16 reloads)
//  in_stall is high from the cycle after accept until the result is registered
//  a held result on the output does not stop the next item from being accepted
//  reset is asynchronous; counters and levels clear, noise register seeds to 0x4000
`timescale 1ns / 1ps
`default_nettype none

module programmable_sound_generator
    import pgsnd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               kind,
    input  wire logic [7:0]         data,
    input  wire logic [7:0]         cycles,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      mixed_sample,
    output logic [3:0]              channel_levels
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,   // waiting for an item
        ST_SUB    = 5'b00010,   // counter minus tick cycles
        ST_RELOAD = 5'b00100,   // add reload while counter is not positive
        ST_MIX    = 5'b01000,   // accumulate the four signed amplitudes
        ST_HOLD   = 5'b10000    // result ready, output register still full
    } state_t;

    state_t                    state_reg, state_next;
    logic [1:0]                ch_reg, ch_next;
    logic [1:0]                mix_idx_reg, mix_idx_next;
    logic [7:0]                cyc_reg, cyc_next;
    logic signed [ADD_W-1:0]   acc_reg, acc_next;
    logic signed [CNT_W-1:0]   ctr_reg [4];
    logic [3:0]                level_reg, level_next;
    logic [NOISE_W-1:0]        noise_reg, noise_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [15:0]        sample_reg, sample_next;
    logic [3:0]                levels_out_reg, levels_out_next;

    logic                      accept;
    logic                      wr_en;
    logic                      ctr_we;
    logic                      can_load;
    logic                      ctr_all_nonneg;
    pgsnd_rd_t                 rd;

    // shared adder
    logic signed [ADD_W-1:0]   add_a, add_b, add_sum;
    logic signed [CNT_W-1:0]   ctr_sum;
    logic                      ctr_pos;
    logic signed [ADD_W-1:0]   ctr_ext;
    logic signed [ADD_W-1:0]   amp_ext;
    logic                      fb;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign can_load = !out_valid_reg || !out_stall;
    assign wr_en    = accept && !kind;

    pgsnd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (data),
        .ch_sel  (ch_reg),
        .mix_sel (mix_idx_reg),
        .rd      (rd)
    );

    // round to nearest (the +2 is preloaded in the accumulator), then saturate
    function automatic logic signed [15:0] to_sample(input logic signed [ADD_W-1:0] s);
        logic signed [ADD_W-1:0] q;
        q = s >>> 2;
        if (q > $signed(ADD_W'(32767)))
            return 16'sd32767;
        return q[15:0];
    endfunction

    assign ctr_ext = {{(ADD_W-CNT_W){ctr_reg[ch_reg][CNT_W-1]}}, ctr_reg[ch_reg]};
    assign amp_ext = level_reg[mix_idx_reg] ? $signed({{(ADD_W-16){1'b0}}, rd.amp})
                                            : -$signed({{(ADD_W-16){1'b0}}, rd.amp});

    always_comb
    begin
        add_a = '0;
        add_b = '0;
        unique case (state_reg)
            ST_SUB:
            begin
                add_a = ctr_ext;
                add_b = -$signed({{(ADD_W-8){1'b0}}, cyc_reg});
            end
            ST_RELOAD:
            begin
                add_a = ctr_ext;
                add_b = $signed({{(ADD_W-RLD_W){1'b0}}, rd.reload});
            end
            ST_MIX:
            begin
                add_a = (mix_idx_reg == 2'd0) ? $signed(ADD_W'(2)) : acc_reg;
                add_b = amp_ext;
            end
            default:
            begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end

    assign add_sum = add_a + add_b;
    assign ctr_sum = add_sum[CNT_W-1:0];
    assign ctr_pos = !ctr_sum[CNT_W-1] && (ctr_sum != '0);

    // white noise taps bit0 and bit3, periodic noise just bit0
    assign fb = rd.white ? (noise_reg[0] ^ noise_reg[3]) : noise_reg[0];

    always_comb
    begin
        state_next      = state_reg;
        ch_next         = ch_reg;
        mix_idx_next    = mix_idx_reg;
        cyc_next        = cyc_reg;
        acc_next        = acc_reg;
        level_next      = level_reg;
        noise_next      = noise_reg;
        ctr_we          = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        sample_next     = sample_reg;
        levels_out_next = levels_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cyc_next     = cycles;
                    ch_next      = 2'd0;
                    mix_idx_next = 2'd0;
                    // a write goes straight to the mix
                    state_next   = kind ? ST_SUB : ST_MIX;
                end
            end
            ST_SUB:
            begin
                ctr_we = 1'b1;
                if (!ctr_pos)
                    state_next = ST_RELOAD;
                else if (ch_reg == 2'd3)
                    state_next = ST_MIX;
                else
                    ch_next = ch_reg + 2'd1;
            end
            ST_RELOAD:
            begin
                ctr_we = 1'b1;
                if (ch_reg == 2'd3)
                begin
                    noise_next    = {fb, noise_reg[NOISE_W-1:1]};
                    level_next[3] = noise_reg[1];
                end
                else
                    level_next[ch_reg] = !level_reg[ch_reg];
                if (ctr_pos)
                begin
                    if (ch_reg == 2'd3)
                        state_next = ST_MIX;
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = ST_SUB;
                    end
                end
            end
            ST_MIX:
            begin
                acc_next     = add_sum;
                mix_idx_next = mix_idx_reg + 2'd1;
                if (mix_idx_reg == 2'd3)
                begin
                    if (can_load)
                    begin
                        out_valid_next  = 1'b1;
                        sample_next     = to_sample(add_sum);
                        levels_out_next = level_reg;
                        state_next      = ST_IDLE;
                    end
                    else
                        state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    sample_next     = to_sample(acc_reg);
                    levels_out_next = level_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            mix_idx_reg   <= '0;
            level_reg     <= '0;
            noise_reg     <= NOISE_SEED;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                ctr_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            mix_idx_reg   <= mix_idx_next;
            level_reg     <= level_next;
            noise_reg     <= noise_next;
            out_valid_reg <= out_valid_next;
            if (ctr_we)
                ctr_reg[ch_reg] <= ctr_sum;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cyc_reg        <= cyc_next;
        acc_reg        <= acc_next;
        sample_reg     <= sample_next;
        levels_out_reg <= levels_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign mixed_sample   = sample_reg;
    assign channel_levels = levels_out_reg;

    // checks
    assign ctr_all_nonneg = !ctr_reg[0][CNT_W-1] && !ctr_reg[1][CNT_W-1]
                         && !ctr_reg[2][CNT_W-1] && !ctr_reg[3][CNT_W-1];

`include "programmable_sound_generator_assert.svh"

    `PGSND_ASSERT_NXT(a_busy_after_accept, accept, in_stall, "block not busy after accept")
    `PGSND_ASSERT_NOW(a_ctr_nonneg_idle, state_reg == ST_IDLE, ctr_all_nonneg, "counter negative")
    `PGSND_ASSERT_NOW(a_mix_idx_clear, state_reg != ST_MIX, mix_idx_reg == 2'd0, "mix index set")
    `PGSND_ASSERT_NXT(a_result_only_at_end, !out_valid_reg && state_reg != ST_MIX && state_reg != ST_HOLD, !out_valid_reg, "result without a mix")

endmodule

`default_nettype wire

// ----- tb/sv/programmable_sound_generator_tb.sv -----
// self-checking testbench of the programmable sound generator
`timescale 1ns / 1ps

module programmable_sound_generator_tb
    import pgsnd_pkg::*;
();

    // item kinds on the input channel
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // register byte layout
    localparam int LATCH_BIT       = 7;
    localparam int VOL_BIT         = 4;
    localparam int CH_NOISE        = 3;
    localparam int NOISE_WHITE_BIT = 2;
    localparam logic SEL_PERIOD    = 1'b0;
    localparam logic SEL_VOLUME    = 1'b1;

    // run length and guards
    localparam int ITEM_TARGET    = 1850;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 100;

    // predicts the mixed sample and levels of every accepted item and checks the results
    class mix_sample_checker;
        typedef struct {
            logic signed [15:0] sample;
            logic [3:0]         levels;
        } mix_result_t;

        logic [PERIOD_W-1:0] period_q [4];
        logic [3:0]          atten_q [4];
        int                  count_q [4];
        logic                level_q [4];
        logic [NOISE_W-1:0]  lfsr_q;
        logic [1:0]          latch_ch;
        logic                latch_vol;
        int                  amp_tab [16];
        mix_result_t         expected_samples [$];
        int                  errors;

        function new();
            amp_tab = '{32768, 26028, 20677, 16423, 13045, 10361, 8231, 6537,
                        5194, 4125, 3277, 2602, 2068, 1642, 1304, 0};
            for (int i = 0; i < 4; i++)
            begin
                period_q[i] = '0;
                atten_q[i]  = '0;
                count_q[i]  = 0;
                level_q[i]  = 1'b0;
            end
            lfsr_q    = NOISE_SEED;
            latch_ch  = '0;
            latch_vol = 1'b0;
            errors    = 0;
        endfunction

        function int tone_reload(int ch);
            int p;
            p = period_q[ch];
            if (p == 0)
                p = 1;
            return p * PRESCALE;
        endfunction

        function void note_item(logic k, logic [7:0] d, logic [7:0] c);
            int          rld;
            int          sum;
            int          mix;
            logic        fb;
            mix_result_t res;
            if (k == KIND_TICK)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    rld = tone_reload(ch);
                    count_q[ch] -= int'(c);
                    while (count_q[ch] <= 0)
                    begin
                        count_q[ch] += rld;
                        level_q[ch] = ~level_q[ch];
                    end
                end
                case (period_q[CH_NOISE][1:0])
                    2'd0:    rld = PRESCALE;
                    2'd1:    rld = 2 * PRESCALE;
                    2'd2:    rld = 4 * PRESCALE;
                    default: rld = tone_reload(2);
                endcase
                count_q[CH_NOISE] -= int'(c);
                while (count_q[CH_NOISE] <= 0)
                begin
                    count_q[CH_NOISE] += rld;
                    fb = period_q[CH_NOISE][NOISE_WHITE_BIT] ? (lfsr_q[0] ^ lfsr_q[3])
                                                             : lfsr_q[0];
                    lfsr_q = {fb, lfsr_q[NOISE_W-1:1]};
                    level_q[CH_NOISE] = lfsr_q[0];
                end
            end
            else if (d[LATCH_BIT])
            begin
                latch_ch  = d[6:5];
                latch_vol = d[VOL_BIT];
                if (latch_vol)
                    atten_q[latch_ch] = d[3:0];
                else
                    period_q[latch_ch][3:0] = d[3:0];
            end
            else if (latch_vol)
                atten_q[latch_ch] = d[3:0];
            else
                period_q[latch_ch][9:4] = d[5:0];

            sum = 0;
            for (int ch = 0; ch < 4; ch++)
                sum += level_q[ch] ? amp_tab[atten_q[ch]] : -amp_tab[atten_q[ch]];
            // divide by four, rounding to nearest with ties up, then clip
            mix = (sum + 2) >>> 2;
            if (mix > 32767)
                mix = 32767;
            if (mix < -32768)
                mix = -32768;
            res.sample = mix[15:0];
            res.levels = {level_q[3], level_q[2], level_q[1], level_q[0]};
            expected_samples.insert(expected_samples.size(), res);
        endfunction

        function void check_sample(logic signed [15:0] sample, logic [3:0] levels);
            mix_result_t exp_res;
            if (expected_samples.size() == 0)
            begin
                $error("result with no item pending: mixed_sample %0d channel_levels %h",
                       sample, levels);
                errors++;
                return;
            end
            exp_res = expected_samples.pop_front();
            if (sample !== exp_res.sample)
            begin
                $error("mixed_sample mismatch: expected %0d, actual %0d", exp_res.sample, sample);
                errors++;
            end
            if (levels !== exp_res.levels)
            begin
                $error("channel_levels mismatch: expected %h, actual %h", exp_res.levels, levels);
                errors++;
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               kind = KIND_WRITE;
    logic [7:0]         data = '0;
    logic [7:0]         cycles = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] mixed_sample;
    logic [3:0]         channel_levels;

    mix_sample_checker  mix_checker = new();
    int                 items_sent = 0;
    int                 results_seen = 0;
    bit                 calm_send = 1'b0;
    bit                 calm_recv = 1'b0;

    programmable_sound_generator i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .data           (data),
        .cycles         (cycles),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mixed_sample   (mixed_sample),
        .channel_levels (channel_levels)
    );

    always #1 clk = ~clk;

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    function automatic logic [7:0] latch_byte(int ch, logic sel, logic [3:0] val);
        return {1'b1, 2'(ch), sel, val};
    endfunction

    // attenuation biased toward full scale and silence
    function automatic logic [3:0] pick_atten();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 4'd0;
        else if (r < 50)
            return 4'd15;
        else
            return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [7:0] pick_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'd0;
        else if (r < 20)
            return 8'd255;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // offer one item after a random gap and hold it until the block takes it
    task automatic send_item(logic k, logic [7:0] d, logic [7:0] c);
        int gap;
        gap = calm_send ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        data     <= d;
        cycles   <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        mix_checker.note_item(k, d, c);
        items_sent++;
        // occasionally switch between gappy and back-to-back offering
        if ($urandom_range(0, 99) == 0)
            calm_send = ~calm_send;
    endtask

    // register byte; the cycles field carries noise
    task automatic send_write(logic [7:0] d);
        send_item(KIND_WRITE, d, 8'($urandom_range(0, 255)));
    endtask

    // time tick; the data field carries noise
    task automatic send_tick(logic [7:0] c);
        send_item(KIND_TICK, 8'($urandom_range(0, 255)), c);
    endtask

    // one well-formed register sequence or a short run of ticks, with some stray bytes
    task automatic play_sequence();
        int         r;
        int         ch;
        logic [5:0] hi;
        logic [3:0] lo;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            repeat ($urandom_range(1, 4))
                send_tick(pick_cycles());
        end
        else if (r < 65)
        begin
            // tone period: mostly short periods so the squares toggle often
            ch = $urandom_range(0, 2);
            if ($urandom_range(0, 99) < 8)
            begin
                hi = '0;
                lo = '0;
            end
            else
            begin
                hi = ($urandom_range(0, 99) < 70) ? 6'($urandom_range(0, 3))
                                                  : 6'($urandom_range(0, 63));
                lo = 4'($urandom_range(0, 15));
            end
            send_write(latch_byte(ch, SEL_PERIOD, lo));
            send_write({1'b0, 1'($urandom_range(0, 1)), hi});
        end
        else if (r < 80)
            send_write(latch_byte($urandom_range(0, 3), SEL_VOLUME, pick_atten()));
        else if (r < 88)
            send_write(latch_byte(CH_NOISE, SEL_PERIOD, 4'($urandom_range(0, 15))));
        else if (r < 95)
        begin
            // volume latch followed by a data byte to the same register
            ch = $urandom_range(0, 3);
            send_write(latch_byte(ch, SEL_VOLUME, pick_atten()));
            send_write({1'b0, 3'($urandom_range(0, 7)), pick_atten()});
        end
        else
            send_write(8'($urandom_range(0, 255)));
    endtask

    // receiver: checks every accepted result and drives out_stall
    initial
    begin
        int  stall_left;
        int  hold_left;
        bit  held;
        stall_left = 0;
        hold_left  = 0;
        held       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                mix_checker.check_sample(mixed_sample, channel_levels);
                results_seen++;
            end
            // one long hold-off so the block backs up into its input
            if (!held && results_seen == HOLD_AT_RESULT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if ($urandom_range(0, 199) == 0)
                calm_recv = ~calm_recv;
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!calm_recv && $urandom_range(0, 99) < 30)
                    stall_left = gap_len();
            end
        end
    end

    // watchdog: ends the run after too many cycles with no item moving on either side
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // stimulus
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero tick right after reset: counters at zero still reload
        send_tick(8'd0);
        send_tick(8'd255);
        // volume latches at both extremes, then a data byte into the latched volume
        send_write(latch_byte(0, SEL_VOLUME, 4'd15));
        send_item(KIND_WRITE, latch_byte(1, SEL_VOLUME, 4'd0), 8'd255);
        send_item(KIND_WRITE, 8'h0A, 8'd0);
        // largest tone period, with bit6 of the data byte set
        send_write(latch_byte(0, SEL_PERIOD, 4'hF));
        send_write(8'h7F);
        // zero tone period acts as one
        send_write(latch_byte(2, SEL_PERIOD, 4'h0));
        send_write(8'h00);
        send_item(KIND_TICK, 8'hFF, 8'd255);
        // noise: every rate, each in periodic or white mode
        send_write(latch_byte(CH_NOISE, SEL_PERIOD, 4'h0));
        send_tick(8'd200);
        send_write(latch_byte(CH_NOISE, SEL_PERIOD, 4'h5));
        send_tick(8'd255);
        send_write(latch_byte(CH_NOISE, SEL_PERIOD, 4'h6));
        send_tick(8'd100);
        send_write(latch_byte(CH_NOISE, SEL_PERIOD, 4'h3));
        send_tick(8'd255);
        send_write(latch_byte(CH_NOISE, SEL_PERIOD, 4'h7));
        // data byte to the noise channel only fills the unused period bits
        send_write(8'h2A);
        send_tick(8'd50);
        // channels 0, 2 and noise at full scale
        send_write(latch_byte(CH_NOISE, SEL_VOLUME, 4'd0));
        send_write(latch_byte(2, SEL_VOLUME, 4'd0));
        send_write(latch_byte(0, SEL_VOLUME, 4'd0));
        send_tick(8'd1);

        while (items_sent < ITEM_TARGET)
            play_sequence();
        in_valid <= 1'b0;

        // drain, then give the block time to show any stray result
        while (mix_checker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mix_checker.errors == 0 && mix_checker.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
